// File: rtl/skf_pkg.sv
// Package with the shared types, register codes and constants of the scalar Kalman filter.
package skf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SampW = 16;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DivSteps = 17;
  localparam int unsigned DivCntW = $clog2(DivSteps);

  localparam logic [1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd1;
  localparam logic [1:0] REG_INIT_COV = 2'd2;
  localparam logic [1:0] REG_INIT_EST = 2'd3;

  localparam logic [DataW-1:0] RstProcNoise = 32'd151;
  localparam logic [DataW-1:0] RstMeasNoise = 32'd3718590;
  localparam logic [DataW-1:0] RstInitCov = 32'd1966080;
  localparam logic [DataW-1:0] RstInitEst = 32'd65536;

  localparam logic [SampW:0] QOne = 17'h10000;

  typedef struct packed {
    logic [SampW-1:0] sample;
    logic [SampW-1:0] adjust;
  } skf_in_t;

  typedef struct packed {
    logic [SampW-1:0] filtered;
    logic [SampW-1:0] gain;
  } skf_out_t;

  typedef struct packed {
    logic [DataW-1:0] proc_noise;
    logic [DataW-1:0] meas_noise;
    logic [DataW-1:0] init_cov;
    logic [DataW-1:0] init_est;
  } skf_cfg_t;

  typedef struct packed {
    logic             load_cov;
    logic             load_est;
    logic [DataW-1:0] value;
  } skf_load_t;

endpackage

// File: rtl/skf_regs.sv
// APB register file holding the filter's noise and initial-state registers.
module skf_regs
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output skf_cfg_t         cfg_o,
  output skf_load_t        load_o
);

  logic       wr_en;
  logic [1:0] idx;
  skf_cfg_t   cfg_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.proc_noise <= RstProcNoise;
      cfg_q.meas_noise <= RstMeasNoise;
      cfg_q.init_cov   <= RstInitCov;
      cfg_q.init_est   <= RstInitEst;
    end else if (wr_en) begin
      case (idx)
        REG_PROC_NOISE: cfg_q.proc_noise <= pwdata;
        REG_MEAS_NOISE: cfg_q.meas_noise <= pwdata;
        REG_INIT_COV:   cfg_q.init_cov   <= pwdata;
        REG_INIT_EST:   cfg_q.init_est   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROC_NOISE: prdata = cfg_q.proc_noise;
      REG_MEAS_NOISE: prdata = cfg_q.meas_noise;
      REG_INIT_COV:   prdata = cfg_q.init_cov;
      REG_INIT_EST:   prdata = cfg_q.init_est;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o           = cfg_q;
  assign load_o.load_cov = wr_en && (idx == REG_INIT_COV);
  assign load_o.load_est = wr_en && (idx == REG_INIT_EST);
  assign load_o.value    = pwdata;

endmodule

// File: rtl/skf_div.sv
// Restoring divider that forms the Q0.16 gain one quotient bit per cycle.
module skf_div
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] cp_i,
  input  logic [DataW-1:0] mn_i,
  output logic             done_o,
  output logic [SampW-1:0] gain_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DataW+1:0]   rem_q;
  logic [DataW:0]     den_q;
  logic [SampW:0]     quo_q;
  logic [SampW-1:0]   gain_q;
  logic [DataW+2:0]   diff;
  logic               ge;
  logic [DataW+1:0]   rem_nx;
  logic [SampW:0]     quo_nx;

  assign diff   = {1'b0, rem_q} - {2'b00, den_q};
  assign ge     = !diff[DataW+2];
  assign rem_nx = ge ? diff[DataW+1:0] : rem_q;
  assign quo_nx = {quo_q[SampW-1:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= {1'b0, cp_i} + {1'b0, mn_i};
      rem_q <= {2'b00, cp_i};
      quo_q <= '0;
      cnt_q <= DivCntW'(DivSteps - 1);
    end else if (busy_q) begin
      quo_q <= quo_nx;
      rem_q <= {rem_nx[DataW:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        if (den_q == '0) begin
          gain_q <= '0;
        end else if (quo_nx[SampW]) begin
          gain_q <= '1;
        end else begin
          gain_q <= quo_nx[SampW-1:0];
        end
      end
    end
  end

  assign done_o = done_q;
  assign gain_o = gain_q;

endmodule

// File: rtl/skf_mul.sv
// Shared 32 by 17 bit multiplier with a registered product.
module skf_mul
  import skf_pkg::*;
(
  input  logic                   clk_i,
  input  logic [DataW-1:0]       a_i,
  input  logic [SampW:0]         b_i,
  output logic [DataW+SampW:0]   prod_o
);

  logic [DataW+SampW:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= {{(SampW+1){1'b0}}, a_i} * {{DataW{1'b0}}, b_i};
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: sequencer, state and handshakes.
//
//  Channel | Direction | Handshake                  | Beat payload
//  --------+-----------+----------------------------+------------------------
//  input   | in        | in_valid_i / in_stall_o    | in_data_i  (skf_in_t)
//  output  | out       | out_valid_o / out_stall_i  | out_data_o (skf_out_t)
//  config  | in        | APB psel/penable/pready    | pwdata, prdata (32 bit)
//
// Each beat passes through prediction, the 17-step gain divider and then two
// products that share one multiplier before its result is loaded.
// Reset loads the register defaults and the initial estimate and covariance.
// The finished result waits in an output register, so a new beat is taken
// while the previous result is still stalled; a second result waits in the
// sequencer until the output register is free.
module scalar_kalman_filter
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  skf_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output skf_out_t         out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRED  = 3'd1;
  localparam logic [2:0] S_DIVST = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  skf_cfg_t             cfg;
  skf_load_t            load;
  logic [2:0]           state_q;
  logic [2:0]           state_d;
  skf_in_t              in_q;
  logic [DataW-1:0]     est_q;
  logic [DataW-1:0]     cov_q;
  logic [DataW-1:0]     pred_q;
  logic [DataW-1:0]     cp_q;
  logic [DataW-1:0]     mag_q;
  logic                 up_q;
  logic [SampW-1:0]     gain_q;
  logic [DataW-1:0]     step_q;
  skf_out_t             res_q;
  logic                 out_valid_q;
  skf_out_t             out_data_q;
  logic                 in_acc;
  logic                 out_free;
  logic [DataW:0]       pred_sum;
  logic [DataW:0]       cp_sum;
  logic [DataW-1:0]     meas;
  logic                 div_start;
  logic                 div_done;
  logic [SampW-1:0]     div_gain;
  logic [DataW-1:0]     mul_a;
  logic [SampW:0]       mul_b;
  logic [DataW+SampW:0] prod;
  logic [DataW-1:0]     est_new;
  logic [DataW-1:0]     cov_new;

  skf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .load_o  (load)
  );

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .cp_i    (cp_q),
    .mn_i    (cfg.meas_noise),
    .done_o  (div_done),
    .gain_o  (div_gain)
  );

  skf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_start  = (state_q == S_DIVST);

  assign pred_sum = {1'b0, est_q} + {1'b0, in_q.adjust, {SampW{1'b0}}};
  assign cp_sum   = {1'b0, cov_q} + {1'b0, cfg.proc_noise};
  assign meas     = {in_q.sample, {SampW{1'b0}}};

  always_comb begin
    if (state_q == S_MUL2) begin
      mul_a = cp_q;
      mul_b = QOne - {1'b0, gain_q};
    end else begin
      mul_a = mag_q;
      mul_b = {1'b0, gain_q};
    end
  end

  assign est_new = up_q ? (pred_q + step_q) : (pred_q - step_q);
  assign cov_new = prod[DataW+SampW-1:SampW];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_PRED;
      S_PRED:  state_d = S_DIVST;
      S_DIVST: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_UPD;
      S_UPD:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      est_q       <= RstInitEst;
      cov_q       <= RstInitCov;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == S_UPD) begin
        est_q <= est_new;
        cov_q <= cov_new;
      end else begin
        if (load.load_est) est_q <= load.value;
        if (load.load_cov) cov_q <= load.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (state_q == S_PRED) begin
      pred_q <= pred_sum[DataW] ? '1 : pred_sum[DataW-1:0];
      cp_q   <= cp_sum[DataW] ? '1 : cp_sum[DataW-1:0];
    end
    if (state_q == S_DIVST) begin
      up_q  <= (meas >= pred_q);
      mag_q <= (meas >= pred_q) ? (meas - pred_q) : (pred_q - meas);
    end
    if ((state_q == S_DIV) && div_done) begin
      gain_q <= div_gain;
    end
    if (state_q == S_MUL2) begin
      step_q <= prod[DataW+SampW-1:SampW];
    end
    if (state_q == S_UPD) begin
      res_q.filtered <= est_new[DataW-1:SampW];
      res_q.gain     <= gain_q;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_cov_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (cov_new <= cp_q))
    else $error("covariance update grew past the predicted covariance");

  a_est_toward_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (up_q ? (est_new >= pred_q) : (est_new <= pred_q)))
    else $error("estimate moved away from the sample");

  a_result_follows_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (state_q == S_OUT))
    else $error("update not followed by result hand-off");

endmodule

// File: sim/testbench.sv
// Testbench for the scalar Kalman filter: directed and random beats checked against a bit-exact predictor.
module testbench;
  import skf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemsPerPhase = 229;
  localparam int unsigned NumPhases = 8;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  skf_in_t          in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  skf_out_t         out_data_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  scalar_kalman_filter u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  skf_in_t     pending_samples[$];
  skf_out_t    expected_outputs[$];
  int unsigned beats_total = 0;
  int unsigned beats_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_odds = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  logic        in_taken = 1'b0;

  logic [31:0] proc_noise_q = 32'd151;
  logic [31:0] meas_noise_q = 32'd3718590;
  logic [31:0] est_q = 32'd65536;
  logic [31:0] cov_q = 32'd1966080;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic skf_out_t kalman_step(skf_in_t beat);
    logic [63:0] pred, cp, denom, quot, meas, delta, prod;
    logic [15:0] g;
    skf_out_t    res;
    pred = {32'd0, est_q} + {32'd0, beat.adjust, 16'd0};
    if (pred > 64'hFFFF_FFFF) pred = 64'hFFFF_FFFF;
    cp = {32'd0, cov_q} + {32'd0, proc_noise_q};
    if (cp > 64'hFFFF_FFFF) cp = 64'hFFFF_FFFF;
    denom = cp + {32'd0, meas_noise_q};
    if (denom == 64'd0) begin
      g = 16'd0;
    end else begin
      quot = (cp << 16) / denom;
      g = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
    end
    meas = {32'd0, beat.sample, 16'd0};
    if (meas >= pred) begin
      delta = ({48'd0, g} * (meas - pred)) >> 16;
      est_q = pred[31:0] + delta[31:0];
    end else begin
      delta = ({48'd0, g} * (pred - meas)) >> 16;
      est_q = pred[31:0] - delta[31:0];
    end
    prod = (cp * (64'd65536 - {48'd0, g})) >> 16;
    cov_q = prod[31:0];
    res.filtered = est_q[31:16];
    res.gain = g;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      in_valid_i <= 1'b1;
    end else if (in_gap != 0) begin
      in_gap <= in_gap - 1;
      in_valid_i <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      in_gap <= $urandom_range(0, 16);
      in_valid_i <= 1'b0;
    end else if (pending_samples.size() != 0) begin
      in_valid_i <= 1'b1;
      in_data_i <= pending_samples.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      out_gap <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    skf_out_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("output beat with no result pending: filtered %0d gain %0d",
                                    out_data_o.filtered, out_data_o.gain));
        end else begin
          want = expected_outputs.pop_front();
          if (out_data_o.filtered !== want.filtered)
            report_mismatch($sformatf("filtered is %0d, predicted %0d",
                                      out_data_o.filtered, want.filtered));
          if (out_data_o.gain !== want.gain)
            report_mismatch($sformatf("gain is %0d, predicted %0d",
                                      out_data_o.gain, want.gain));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_outputs.push_back(kalman_step(in_data_i));
        beats_taken <= beats_taken + 1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PROC_NOISE: proc_noise_q = val;
      REG_MEAS_NOISE: meas_noise_q = val;
      REG_INIT_COV: cov_q = val;
      REG_INIT_EST: est_q = val;
      default: ;
    endcase
  endtask

  task automatic queue_beat(logic [15:0] sample, logic [15:0] adjust);
    skf_in_t beat;
    beat.sample = sample;
    beat.adjust = adjust;
    pending_samples.push_back(beat);
    beats_total++;
  endtask

  task automatic settle();
    do @(negedge clk_i); while (beats_taken != beats_total || expected_outputs.size() != 0);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_reg();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return $urandom_range(0, 65535);
      4: return $urandom_range(0, 32'h0100_0000);
      default: return $urandom_range(32'h0001_0000, 32'h1000_0000);
    endcase
  endfunction

  function automatic logic [15:0] rand_adjust();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom_range(0, 15));
      2: return 16'($urandom_range(0, 65535));
      default: return 16'd0;
    endcase
  endfunction

  initial begin
    static int unsigned odds[NumPhases] = '{25, 10, 0, 40, 15, 5, 30, 0};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_odds = 20;
    queue_beat(16'd0, 16'd0);
    queue_beat(16'd65535, 16'd0);
    queue_beat(16'd65535, 16'd0);
    queue_beat(16'd0, 16'd65535);
    queue_beat(16'd12345, 16'd0);
    queue_beat(16'd0, 16'd0);
    settle();

    write_reg(REG_MEAS_NOISE, 32'd0);
    queue_beat(16'd100, 16'd0);
    queue_beat(16'd65535, 16'd3);
    queue_beat(16'd0, 16'd0);
    settle();

    write_reg(REG_PROC_NOISE, 32'd0);
    write_reg(REG_INIT_COV, 32'd0);
    queue_beat(16'd500, 16'd0);
    queue_beat(16'd7, 16'd1);
    settle();

    write_reg(REG_PROC_NOISE, 32'hFFFF_FFFF);
    write_reg(REG_MEAS_NOISE, 32'hFFFF_FFFF);
    write_reg(REG_INIT_COV, 32'hFFFF_FFFF);
    write_reg(REG_INIT_EST, 32'hFFFF_FFFF);
    queue_beat(16'd0, 16'd0);
    queue_beat(16'd65535, 16'd65535);
    queue_beat(16'd1, 16'd0);
    settle();

    write_reg(REG_PROC_NOISE, 32'd1);
    write_reg(REG_MEAS_NOISE, 32'd1);
    write_reg(REG_INIT_COV, 32'd1);
    write_reg(REG_INIT_EST, 32'd0);
    queue_beat(16'd0, 16'd0);
    queue_beat(16'd65535, 16'd0);
    queue_beat(16'd32768, 16'd32768);
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) begin
        write_reg(REG_PROC_NOISE, 32'd151);
        write_reg(REG_MEAS_NOISE, 32'd3718590);
        write_reg(REG_INIT_COV, 32'd1966080);
        write_reg(REG_INIT_EST, 32'd65536);
      end else begin
        write_reg(REG_PROC_NOISE, rand_reg());
        write_reg(REG_MEAS_NOISE, rand_reg());
        write_reg(REG_INIT_COV, rand_reg());
        write_reg(REG_INIT_EST, rand_reg());
      end
      idle_odds = odds[p];
      for (int i = 0; i < ItemsPerPhase; i++)
        queue_beat(16'($urandom_range(0, 65535)), rand_adjust());
      settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
